/* rtl/core/dns_compressed_name_length_unit_macros.svh */
// Assertion macros for the DNS compressed-name length unit.
// Included by the top level; expects clk and rst in the including scope.
`ifndef DNS_COMPRESSED_NAME_LENGTH_UNIT_MACROS_SVH
`define DNS_COMPRESSED_NAME_LENGTH_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define DCNL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define DCNL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/dcnl_pkg.sv */
// Shared types and constants for the DNS compressed-name length unit.
// No dependencies; imported by the walker and the top level.
package dcnl_pkg;

  localparam int MAX_NAME_LEN = 255;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNC     = 3'd1,
    ST_PTR_OOB   = 3'd2,
    ST_LOOP      = 3'd3,
    ST_BAD_LABEL = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_t;

  // Walker sequencer states
  typedef enum logic [2:0] {
    WK_IDLE,
    WK_FETCH,
    WK_TAG,
    WK_PTR_LO,
    WK_DONE
  } walk_state_t;

  // Measure request from the input side
  typedef struct packed {
    logic        start;
    logic [11:0] offset;
    logic [12:0] packet_length;
  } req_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic [7:0]  name_length;
    logic [12:0] end_offset;
    logic [12:0] consumed_bytes;
  } res_t;

endpackage

/* rtl/core/dcnl_pkt_mem.sv */
// Packet byte store: one write port, one read port, registered read data.
// Depends on nothing.
module dcnl_pkt_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write a stored byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read with registered output data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/dcnl_walker.sv */
// Label walk sequencer: reads the packet store one byte at a time and
// follows compression pointers. Depends on dcnl_pkg.
module dcnl_walker #(
  parameter int PKT_DEPTH    = 4096,
  parameter int MAX_POINTERS = 256,
  parameter int AW           = 12,
  parameter int PW           = 14
) (
  input  logic            clk,
  input  logic            rst,
  input  dcnl_pkg::req_t  req,
  output logic            idle,
  output logic [AW-1:0]   rd_addr,
  input  logic [7:0]      rd_data,
  output logic            res_valid,
  output dcnl_pkg::res_t  res,
  input  logic            res_take
);

  import dcnl_pkg::*;

  localparam int CW = $clog2(MAX_POINTERS + 2);

  walk_state_t   state, state_next;
  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] limit, limit_next;
  logic [PW-1:0] endpos, endpos_next;
  logic [11:0]   start_off, start_off_next;
  logic [8:0]    len, len_next;
  logic [CW-1:0] ptrs, ptrs_next;
  logic          jumped, jumped_next;
  logic [5:0]    hi, hi_next;
  res_t          res_next;

  logic          fin;
  status_t       fin_status;
  logic [8:0]    len_sum;
  logic [PW-1:0] plen_ext;
  logic [PW-1:0] target;
  logic [PW-1:0] end_pos;

  assign idle      = (state == WK_IDLE);
  assign res_valid = (state == WK_DONE);
  assign rd_addr   = pos[AW-1:0];

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold walk registers
  always_ff @(posedge clk) begin
    pos       <= pos_next;
    limit     <= limit_next;
    endpos    <= endpos_next;
    start_off <= start_off_next;
    len       <= len_next;
    ptrs      <= ptrs_next;
    jumped    <= jumped_next;
    hi        <= hi_next;
    res       <= res_next;
  end

  // Advance the walk one step
  always_comb begin
    state_next     = state;
    pos_next       = pos;
    limit_next     = limit;
    endpos_next    = endpos;
    start_off_next = start_off;
    len_next       = len;
    ptrs_next      = ptrs;
    jumped_next    = jumped;
    hi_next        = hi;
    res_next       = res;
    fin            = 1'b0;
    fin_status     = ST_OK;
    len_sum        = len + 9'd1 + {1'b0, rd_data};
    plen_ext       = PW'(req.packet_length);
    target         = PW'({hi, rd_data});
    end_pos        = jumped ? endpos : pos;

    case (state)
      WK_IDLE: begin
        if (req.start) begin
          pos_next       = PW'(req.offset);
          limit_next     = (plen_ext > PW'(PKT_DEPTH)) ? PW'(PKT_DEPTH) : plen_ext;
          start_off_next = req.offset;
          len_next       = '0;
          ptrs_next      = '0;
          jumped_next    = 1'b0;
          endpos_next    = '0;
          state_next     = WK_FETCH;
        end
      end
      WK_FETCH: begin
        if (pos >= limit) begin
          fin        = 1'b1;
          fin_status = ST_TRUNC;
        end else begin
          pos_next   = pos + PW'(1);
          state_next = WK_TAG;
        end
      end
      WK_TAG: begin
        if (rd_data[7:6] == 2'b11) begin
          // Pointer: fetch the low byte
          if (pos >= limit) begin
            fin        = 1'b1;
            fin_status = ST_TRUNC;
          end else begin
            hi_next    = rd_data[5:0];
            pos_next   = pos + PW'(1);
            state_next = WK_PTR_LO;
          end
        end else if (rd_data[7:6] != 2'b00) begin
          fin        = 1'b1;
          fin_status = ST_BAD_LABEL;
        end else if (len_sum > 9'(MAX_NAME_LEN)) begin
          fin        = 1'b1;
          fin_status = ST_TOO_LONG;
        end else if (rd_data == 8'd0) begin
          // Terminating zero label
          len_next   = len_sum;
          fin        = 1'b1;
          fin_status = ST_OK;
        end else if ((limit - pos) < PW'(rd_data[5:0])) begin
          fin        = 1'b1;
          fin_status = ST_TRUNC;
        end else begin
          len_next   = len_sum;
          pos_next   = pos + PW'(rd_data[5:0]);
          state_next = WK_FETCH;
        end
      end
      WK_PTR_LO: begin
        if (ptrs > CW'(MAX_POINTERS)) begin
          fin        = 1'b1;
          fin_status = ST_LOOP;
        end else if (target >= limit) begin
          fin        = 1'b1;
          fin_status = ST_PTR_OOB;
        end else begin
          ptrs_next = ptrs + CW'(1);
          if (!jumped) begin
            endpos_next = pos;
            jumped_next = 1'b1;
          end
          pos_next   = target;
          state_next = WK_FETCH;
        end
      end
      WK_DONE: begin
        if (res_take) begin
          state_next = WK_IDLE;
        end
      end
      default: begin
        state_next = WK_IDLE;
      end
    endcase

    // Build the result; error results carry zero fields
    if (fin) begin
      state_next      = WK_DONE;
      res_next.status = fin_status;
      if (fin_status == ST_OK) begin
        res_next.name_length    = len_sum[7:0];
        res_next.end_offset     = end_pos[12:0];
        res_next.consumed_bytes = 13'(end_pos - PW'(start_off));
      end else begin
        res_next.name_length    = '0;
        res_next.end_offset     = '0;
        res_next.consumed_bytes = '0;
      end
    end
  end

endmodule

/* rtl/core/dns_compressed_name_length_unit.sv */
// DNS compressed-name length unit. Requests with tuser low store one packet
// byte (the address wraps at PKT_DEPTH). Requests with tuser high measure
// the wire-format name at the given offset, following 14-bit compression
// pointers, and return one result: status, name length, end offset and
// bytes consumed. A measure visits WK_FETCH and WK_TAG per label, plus
// WK_PTR_LO per pointer, a start and a hand-off state: every byte visited
// costs one access to the single read port of the packet memory, whose read
// data is registered. The hand-off stretches while a full output register
// waits on m_tready. No request is taken while a walk runs; one finished
// result may wait in the output register while the next request is taken.
module dns_compressed_name_length_unit #(
  parameter int PKT_DEPTH    = 4096,
  parameter int MAX_POINTERS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // offset[11:0], byte_value[19:12], packet_length[32:20]
  input  logic        s_tuser,   // action: 0 store byte, 1 measure name
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[2:0], name_length[10:3], end_offset[23:11],
                                 // consumed_bytes[36:24]
);

  import dcnl_pkg::*;

  localparam int AW  = $clog2(PKT_DEPTH);
  localparam int DW1 = $clog2(PKT_DEPTH + 1);
  localparam int PW  = (DW1 > 14) ? DW1 : 14;

  logic          accept;
  logic          we;
  logic [16:0]   wrem;
  logic [AW-1:0] waddr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          walk_idle;
  logic          res_valid;
  logic          res_take;
  req_t          req;
  res_t          res;
  res_t          out_res;

  assign accept   = s_tvalid & s_tready;
  assign s_tready = walk_idle;
  assign we       = accept & ~s_tuser;

  // Reduce the store address modulo the depth
  always_comb begin
    wrem = 17'(s_tdata[11:0]);
    for (int i = 2; i >= 0; i--) begin
      if (wrem >= 17'(PKT_DEPTH << i)) begin
        wrem = wrem - 17'(PKT_DEPTH << i);
      end
    end
  end
  assign waddr = wrem[AW-1:0];

  // Unpack a measure request
  always_comb begin
    req.start         = accept & s_tuser;
    req.offset        = s_tdata[11:0];
    req.packet_length = s_tdata[32:20];
  end

  dcnl_pkt_mem #(
    .DEPTH (PKT_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (s_tdata[19:12]),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  dcnl_walker #(
    .PKT_DEPTH    (PKT_DEPTH),
    .MAX_POINTERS (MAX_POINTERS),
    .AW           (AW),
    .PW           (PW)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .idle      (walk_idle),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Load the output register when it is empty or draining
  assign res_take = res_valid & (~m_tvalid | m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res.consumed_bytes, out_res.end_offset,
                    out_res.name_length, out_res.status};

`include "dns_compressed_name_length_unit_macros.svh"

  `DCNL_ASSERT_NEXT(a_walk_blocks_input, accept && s_tuser, !s_tready,
                    "request taken during walk")
  `DCNL_ASSERT_NOW(a_err_zero, m_tvalid && (out_res.status != ST_OK),
                   (out_res.name_length == 8'd0) && (out_res.end_offset == 13'd0)
                   && (out_res.consumed_bytes == 13'd0),
                   "error result carries data")
  `DCNL_ASSERT_NOW(a_ok_len, m_tvalid && (out_res.status == ST_OK),
                   out_res.name_length != 8'd0, "good name with zero length")

endmodule
